// ----- src/bclts_pkg.sv -----
// Package for the block-cyclic local tile setup block.
// Holds the shared widths and constants; no dependencies.
package bclts_pkg;
   localparam int DIM_BITS_DEF  = 16;
   localparam int GRID_BITS_DEF = 8;
   localparam int REG_BITS      = 13;
   localparam int OFS_BITS      = 22;
   localparam logic [1:0] CSR_ROW_BLOCK_SIZE = 2'd0;
   localparam logic [1:0] CSR_COL_BLOCK_SIZE = 2'd1;
endpackage

// ----- src/bclts_div_stage.sv -----
// One restoring division step with its output registers.
// Depends on bclts_pkg for the block size width.
module bclts_div_stage
   import bclts_pkg::*;
#(
   parameter int DIM_BITS = DIM_BITS_DEF
) (
   input  logic                clock,
   input  logic                en,
   input  logic [REG_BITS-1:0] dvs,
   input  logic [DIM_BITS-1:0] num_in,
   input  logic [REG_BITS-1:0] rem_in,
   input  logic [DIM_BITS-1:0] quo_in,
   output logic [DIM_BITS-1:0] num_out,
   output logic [REG_BITS-1:0] rem_out,
   output logic [DIM_BITS-1:0] quo_out
);
   logic [REG_BITS:0]   trial;
   logic                take;
   logic [DIM_BITS-1:0] num_ff, quo_ff;
   logic [REG_BITS-1:0] rem_ff, rem_in_n;

   always_comb begin
      trial    = {rem_in, num_in[DIM_BITS-1]};
      take     = (trial >= {1'b0, dvs});
      rem_in_n = take ? REG_BITS'(trial - {1'b0, dvs}) : REG_BITS'(trial);
   end

   // advance only when the pipeline moves
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= {num_in[DIM_BITS-2:0], 1'b0};
         rem_ff <= rem_in_n;
         quo_ff <= {quo_in[DIM_BITS-2:0], take};
      end
   end

   assign num_out = num_ff;
   assign rem_out = rem_ff;
   assign quo_out = quo_ff;
endmodule

// ----- src/block_cyclic_local_tile_setup.sv -----
// Local tile setup for a 2D block-cyclic distribution.
// Stages: a setup stage, the divider stages (one divider step each), and an output stage.
// Throughput: one transfer per cycle; the whole pipeline holds while the
// result register is stalled, so only stalls on the result side slow the rate.
// Reset: synchronous, active high; clears valid bits and sets block sizes to 1.
module block_cyclic_local_tile_setup
   import bclts_pkg::*;
#(
   parameter int DIM_BITS  = DIM_BITS_DEF,
   parameter int GRID_BITS = GRID_BITS_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_enable,
   input  logic [1:0]                 csr_index,
   input  logic [REG_BITS-1:0]        csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic signed [DIM_BITS:0]   req_diag_offset,
   input  logic [DIM_BITS-1:0]        req_local_rows,
   input  logic [DIM_BITS-1:0]        req_local_cols,
   input  logic [DIM_BITS-1:0]        req_first_row_block,
   input  logic [DIM_BITS-1:0]        req_first_col_block,
   input  logic [GRID_BITS-1:0]       req_proc_row,
   input  logic [GRID_BITS-1:0]       req_proc_col,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [OFS_BITS-1:0] rsp_first_tile_offset,
   output logic [DIM_BITS-1:0]        rsp_first_local_row_block,
   output logic [DIM_BITS-1:0]        rsp_last_local_row_block,
   output logic [DIM_BITS-1:0]        rsp_row_block_count,
   output logic [DIM_BITS-1:0]        rsp_first_upper_bound,
   output logic [DIM_BITS-1:0]        rsp_first_local_col_block,
   output logic [DIM_BITS-1:0]        rsp_last_local_col_block,
   output logic [DIM_BITS-1:0]        rsp_col_block_count,
   output logic signed [DIM_BITS:0]   rsp_first_lower_bound,
   output logic                       rsp_contract_error
);
   localparam int PW = GRID_BITS + REG_BITS;
   localparam int LW = DIM_BITS + GRID_BITS + REG_BITS + 2;
   localparam int WW = DIM_BITS + REG_BITS;
   localparam int NS = DIM_BITS;

   // configuration registers
   logic [REG_BITS-1:0] row_bs_ff, col_bs_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         row_bs_ff <= REG_BITS'(1);
         col_bs_ff <= REG_BITS'(1);
      end else if (csr_write_enable) begin
         if (csr_index == CSR_ROW_BLOCK_SIZE) row_bs_ff <= csr_write_data;
         if (csr_index == CSR_COL_BLOCK_SIZE) col_bs_ff <= csr_write_data;
      end
   end

   // a zero block size counts as one
   logic [REG_BITS-1:0] mb, nb;
   assign mb = (row_bs_ff == '0) ? REG_BITS'(1) : row_bs_ff;
   assign nb = (col_bs_ff == '0) ? REG_BITS'(1) : col_bs_ff;

   // the whole pipeline moves together; hold everything while the result waits
   logic adv;
   assign adv       = !(rsp_valid && rsp_stall);
   assign req_stall = !adv;

   // ---------------- setup stage (combinational part) ----------------
   logic                  empty, r_nf, c_nf, err;
   logic [PW-1:0]         rprod, cprod;
   logic signed [LW-1:0]  off_x, mb_x, nb_x, i1_x, j1_x, rp_x, cp_x, lcm, iupp_x, ilow_x;
   logic [WW-1:0]         iupp_raw, ilow_mag;
   logic [DIM_BITS-1:0]   d_row, d_col, fb_row, fb_col, t_row, t_col;
   logic                  tz_row, tz_col;
   logic signed [OFS_BITS-1:0] lcm_sat;
   logic [DIM_BITS-1:0]   iupp_sat;
   logic signed [DIM_BITS:0]   ilow_sat;

   always_comb begin
      empty = (req_local_rows == '0) || (req_local_cols == '0);
      r_nf  = (req_proc_row != '0);
      c_nf  = (req_proc_col != '0);
      err   = !empty && ((!r_nf && (req_first_row_block > req_local_rows)) ||
                         (!c_nf && (req_first_col_block > req_local_cols)));
      rprod = PW'(req_proc_row) * PW'(mb);
      cprod = PW'(req_proc_col) * PW'(nb);
      off_x = LW'(req_diag_offset);
      mb_x  = $signed(LW'(mb));
      nb_x  = $signed(LW'(nb));
      i1_x  = $signed(LW'(req_first_row_block));
      j1_x  = $signed(LW'(req_first_col_block));
      rp_x  = $signed(LW'(rprod));
      cp_x  = $signed(LW'(cprod));

      // bound seeds: block size minus one, or first block minus one floored at 0
      iupp_raw = r_nf ? WW'(mb - REG_BITS'(1)) :
                 ((req_first_row_block != '0) ? WW'(req_first_row_block - DIM_BITS'(1)) : '0);
      ilow_mag = c_nf ? WW'(nb - REG_BITS'(1)) :
                 ((req_first_col_block != '0) ? WW'(req_first_col_block - DIM_BITS'(1)) : '0);
      iupp_x = $signed(LW'(iupp_raw));
      ilow_x = -$signed(LW'(ilow_mag));

      if (empty) begin
         lcm = off_x + ((LW'(1) - nb_x) - ilow_x + cp_x) - (iupp_x - (mb_x - LW'(1)) + rp_x);
      end else begin
         lcm = off_x;
         if (r_nf) lcm = lcm - (i1_x - mb_x + rp_x);
         if (c_nf) lcm = lcm + (j1_x - nb_x + cp_x);
      end

      // saturate to the offset range
      if (lcm > $signed(LW'((1 << (OFS_BITS - 1)) - 1)))
         lcm_sat = OFS_BITS'((1 << (OFS_BITS - 1)) - 1);
      else if (lcm < -$signed(LW'(1 << (OFS_BITS - 1))))
         lcm_sat = OFS_BITS'(1 << (OFS_BITS - 1));
      else
         lcm_sat = OFS_BITS'(lcm);

      iupp_sat = (iupp_raw > WW'({DIM_BITS{1'b1}})) ? {DIM_BITS{1'b1}} : DIM_BITS'(iupp_raw);
      ilow_sat = (DIM_BITS + 1)'(-$signed({1'b0, ilow_mag}));

      // division operands: extent minus one, or remainder after first block minus one
      t_row  = req_local_rows - req_first_row_block;
      t_col  = req_local_cols - req_first_col_block;
      tz_row = !r_nf && (t_row == '0);
      tz_col = !c_nf && (t_col == '0);
      d_row  = r_nf ? req_local_rows - DIM_BITS'(1) : t_row - DIM_BITS'(1);
      d_col  = c_nf ? req_local_cols - DIM_BITS'(1) : t_col - DIM_BITS'(1);
      fb_row = r_nf ? ((WW'(req_local_rows) < WW'(mb)) ? req_local_rows : DIM_BITS'(mb))
                    : req_first_row_block;
      fb_col = c_nf ? ((WW'(req_local_cols) < WW'(nb)) ? req_local_cols : DIM_BITS'(nb))
                    : req_first_col_block;
   end

   // ---------------- side data travelling with each stage ----------------
   logic                        v_ff     [0:NS];
   logic                        zero_ff  [0:NS];
   logic                        err_ff   [0:NS];
   logic                        rnf_ff   [0:NS];
   logic                        cnf_ff   [0:NS];
   logic                        tzr_ff   [0:NS];
   logic                        tzc_ff   [0:NS];
   logic [DIM_BITS-1:0]         fbr_ff   [0:NS];
   logic [DIM_BITS-1:0]         fbc_ff   [0:NS];
   logic signed [OFS_BITS-1:0]  lcm_ff   [0:NS];
   logic [DIM_BITS-1:0]         iupp_ff  [0:NS];
   logic signed [DIM_BITS:0]    ilow_ff  [0:NS];

   logic [DIM_BITS-1:0] rnum [0:NS];
   logic [REG_BITS-1:0] rrem [0:NS];
   logic [DIM_BITS-1:0] rquo [0:NS];
   logic [DIM_BITS-1:0] cnum [0:NS];
   logic [REG_BITS-1:0] crem [0:NS];
   logic [DIM_BITS-1:0] cquo [0:NS];

   logic [DIM_BITS-1:0] rnum_ff, cnum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         zero_ff[0] <= empty || err;
         err_ff[0]  <= err;
         rnf_ff[0]  <= r_nf;
         cnf_ff[0]  <= c_nf;
         tzr_ff[0]  <= tz_row;
         tzc_ff[0]  <= tz_col;
         fbr_ff[0]  <= fb_row;
         fbc_ff[0]  <= fb_col;
         lcm_ff[0]  <= lcm_sat;
         iupp_ff[0] <= iupp_sat;
         ilow_ff[0] <= ilow_sat;
         rnum_ff    <= d_row;
         cnum_ff    <= d_col;
      end
   end

   assign rnum[0] = rnum_ff;
   assign cnum[0] = cnum_ff;
   assign rrem[0] = '0;
   assign crem[0] = '0;
   assign rquo[0] = '0;
   assign cquo[0] = '0;

   for (genvar k = 1; k <= NS; k++) begin : g_div
      bclts_div_stage #(.DIM_BITS(DIM_BITS)) u_row (
         .clock(clock), .en(adv), .dvs(mb),
         .num_in(rnum[k-1]), .rem_in(rrem[k-1]), .quo_in(rquo[k-1]),
         .num_out(rnum[k]), .rem_out(rrem[k]), .quo_out(rquo[k])
      );
      bclts_div_stage #(.DIM_BITS(DIM_BITS)) u_col (
         .clock(clock), .en(adv), .dvs(nb),
         .num_in(cnum[k-1]), .rem_in(crem[k-1]), .quo_in(cquo[k-1]),
         .num_out(cnum[k]), .rem_out(crem[k]), .quo_out(cquo[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (adv) begin
            v_ff[k] <= v_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            zero_ff[k] <= zero_ff[k-1];
            err_ff[k]  <= err_ff[k-1];
            rnf_ff[k]  <= rnf_ff[k-1];
            cnf_ff[k]  <= cnf_ff[k-1];
            tzr_ff[k]  <= tzr_ff[k-1];
            tzc_ff[k]  <= tzc_ff[k-1];
            fbr_ff[k]  <= fbr_ff[k-1];
            fbc_ff[k]  <= fbc_ff[k-1];
            lcm_ff[k]  <= lcm_ff[k-1];
            iupp_ff[k] <= iupp_ff[k-1];
            ilow_ff[k] <= ilow_ff[k-1];
         end
      end
   end

   // ---------------- output stage ----------------
   logic                       out_v_ff;
   logic signed [OFS_BITS-1:0] ofs_ff, ofs_in;
   logic [DIM_BITS-1:0]        frb_ff, frb_in, lrb_ff, lrb_in, rbc_ff, rbc_in, upp_ff, upp_in;
   logic [DIM_BITS-1:0]        fcb_ff, fcb_in, lcb_ff, lcb_in, cbc_ff, cbc_in;
   logic signed [DIM_BITS:0]   low_ff, low_in;
   logic                       cerr_ff, cerr_in;

   always_comb begin
      cerr_in = err_ff[NS];
      ofs_in  = lcm_ff[NS];
      upp_in  = iupp_ff[NS];
      low_in  = ilow_ff[NS];
      frb_in  = fbr_ff[NS];
      fcb_in  = fbc_ff[NS];
      // count is quotient plus one (not first) or plus two (after the first block)
      rbc_in  = rquo[NS] + (rnf_ff[NS] ? DIM_BITS'(1) : DIM_BITS'(2));
      cbc_in  = cquo[NS] + (cnf_ff[NS] ? DIM_BITS'(1) : DIM_BITS'(2));
      lrb_in  = DIM_BITS'(WW'(rrem[NS]) + WW'(1));
      lcb_in  = DIM_BITS'(WW'(crem[NS]) + WW'(1));
      if (tzr_ff[NS]) begin
         rbc_in = DIM_BITS'(1);
         lrb_in = fbr_ff[NS];
      end
      if (tzc_ff[NS]) begin
         cbc_in = DIM_BITS'(1);
         lcb_in = fbc_ff[NS];
      end
      if (zero_ff[NS]) begin
         frb_in = '0; lrb_in = '0; rbc_in = '0;
         fcb_in = '0; lcb_in = '0; cbc_in = '0;
      end
      // a contract error drops every other field
      if (err_ff[NS]) begin
         ofs_in = '0;
         upp_in = '0;
         low_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (adv) begin
         out_v_ff <= v_ff[NS];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ofs_ff  <= ofs_in;
         frb_ff  <= frb_in;
         lrb_ff  <= lrb_in;
         rbc_ff  <= rbc_in;
         upp_ff  <= upp_in;
         fcb_ff  <= fcb_in;
         lcb_ff  <= lcb_in;
         cbc_ff  <= cbc_in;
         low_ff  <= low_in;
         cerr_ff <= cerr_in;
      end
   end

   assign rsp_valid                 = out_v_ff;
   assign rsp_first_tile_offset     = ofs_ff;
   assign rsp_first_local_row_block = frb_ff;
   assign rsp_last_local_row_block  = lrb_ff;
   assign rsp_row_block_count       = rbc_ff;
   assign rsp_first_upper_bound     = upp_ff;
   assign rsp_first_local_col_block = fcb_ff;
   assign rsp_last_local_col_block  = lcb_ff;
   assign rsp_col_block_count       = cbc_ff;
   assign rsp_first_lower_bound     = low_ff;
   assign rsp_contract_error        = cerr_ff;

   // ---------------- assertions ----------------
   a_err_clears : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_contract_error |->
         rsp_first_tile_offset == '0 && rsp_row_block_count == '0 &&
         rsp_col_block_count == '0 && rsp_first_upper_bound == '0)
      else $error("contract error result carries nonzero fields");

   a_single_row_block : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_block_count == DIM_BITS'(1) |->
         rsp_last_local_row_block == rsp_first_local_row_block)
      else $error("single row block with differing first and last size");

   a_empty_rows : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_block_count == '0 && rsp_first_local_row_block != '0 |->
         rsp_col_block_count != '0)
      else $error("zero row count with nonzero first row block");
endmodule
